// File: rtl/trod_pkg.sv
package trod_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int SIZE_W        = 5;
  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_WRITE_R = 2'd0,
    FUNC_READ_R  = 2'd1,
    FUNC_WRITE_V = 2'd2,
    FUNC_RUN     = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_PIVOT = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // One decoded word as it travels from the front end to the engine.
  typedef struct packed {
    func_t       func;
    logic        row_ok;
    logic        col_ok;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_COL_RD,
    ST_COL_LD,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_C,
    ST_SQRT,
    ST_DIAG,
    ST_DIV_C,
    ST_DIV_S,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_M1,
    ST_M1W,
    ST_DIV_R,
    ST_M2,
    ST_M3,
    ST_DONE
  } engine_state_t;

  // Signed add of two words, saturated to 32 bits.
  function automatic sat_word_t add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sat_word_t   r;
    sum = {a[31], a} + {b[31], b};
    r.sat = sum[32] != sum[31];
    r.val = r.sat ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
    return r;
  endfunction

endpackage

// File: rtl/triangular_rank_one_downdate_unit.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   func, row_index, col_index, data_value
// out       out_valid / out_ready read_value, status
// cfg       cfg_we                cfg_data (active_size)
//
// A downdate of order n runs through a bit-serial divider.
// Reset clears the control state only; both stores hold garbage until written.
// A two-word queue accepts words while the engine works or the result waits, until it is full.
module triangular_rank_one_downdate_unit import trod_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [3:0]        row_index,
  input  logic [3:0]        col_index,
  input  logic [31:0]       data_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       read_value,
  output logic [1:0]        status
);

  logic [SIZE_W-1:0] active_size;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RESET;
    end else if (cfg_we) begin
      active_size <= cfg_data;
    end
  end

  trod_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .row_index  (row_index),
    .col_index  (col_index),
    .data_value (data_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  trod_engine #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .active_size (active_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status)
  );

endmodule

// File: rtl/trod_front.sv
module trod_front import trod_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  row_index,
  input  logic [3:0]  col_index,
  input  logic [31:0] data_value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       incoming;
  logic       push;

  always_comb begin
    incoming.func   = func_t'(func);
    incoming.row_ok = 32'(row_index) < 32'(MAX_ORDER);
    incoming.col_ok = 32'(col_index) < 32'(MAX_ORDER);
    incoming.row    = row_index;
    incoming.col    = col_index;
    incoming.data   = data_value;
  end

  assign in_ready  = count != 2'd2;
  assign push      = in_valid && in_ready;
  assign cmd_valid = count != 2'd0;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// File: rtl/trod_div.sv
module trod_div import trod_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot,
  output logic        quot_sat
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    dvd;
  logic [NW-1:0]    q;
  logic [31:0]      rem;
  logic [31:0]      dmag;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      nmag;
  logic [32:0]      rem_sh;
  logic             ge;

  assign nmag   = num[32] ? 33'(-num) : num;
  assign rem_sh = {rem, dvd[NW-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nmag[31:0], {FRAC_BITS{1'b0}}};
      dmag <= den[31] ? 32'(-den) : den;
      neg  <= num[32] ^ den[31];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      q   <= {q[NW-2:0], ge};
      rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The magnitude is truncated, so negating it rounds toward zero.
  always_comb begin
    if (neg) begin
      quot_sat = (|q[NW-1:32]) || (q[31] && (|q[30:0]));
      quot     = quot_sat ? 32'h8000_0000 : 32'(-q[31:0]);
    end else begin
      quot_sat = |q[NW-1:31];
      quot     = quot_sat ? 32'h7FFF_FFFF : q[31:0];
    end
  end

endmodule

// File: rtl/trod_sqrt.sv
module trod_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] rad,
  output logic        done,
  output logic [31:0] root,
  output logic        root_sat
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        busy;
  logic [5:0]  cnt;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= {1'b0, rad};
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Any root of 2^31 or more saturates; from the engine's radicand of at most 2^62 only 2^31 can.
  assign root_sat = res[31];
  assign root     = res[31] ? 32'h7FFF_FFFF : res[31:0];

endmodule

// File: rtl/trod_engine.sv
module trod_engine import trod_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [SIZE_W-1:0] active_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       read_value,
  output logic [1:0]        status
);

  localparam int IDX_W  = $clog2(MAX_ORDER);
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);
  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = $clog2(DEPTH);

  engine_state_t state, state_next;

  logic [31:0] fac_mem [DEPTH];
  logic [31:0] vec_mem [MAX_ORDER];
  logic [31:0] fac_q;
  logic [31:0] vec_q;

  logic              fac_we;
  logic [ADDR_W-1:0] fac_waddr;
  logic [ADDR_W-1:0] fac_raddr;
  logic [31:0]       fac_wdata;
  logic              vec_we;
  logic [IDX_W-1:0]  vec_waddr;
  logic [IDX_W-1:0]  vec_raddr;
  logic [31:0]       vec_wdata;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  logic        div_start;
  logic [32:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [31:0] div_q;
  logic        div_sat;

  logic        sqrt_start;
  logic [62:0] sqrt_rad;
  logic        sqrt_done;
  logic [31:0] sqrt_root;
  logic        sqrt_sat;

  logic [CNT_W-1:0] i_cnt;
  logic [CNT_W-1:0] j_cnt;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] i_ix;
  logic [IDX_W-1:0] j_ix;
  logic             last_col;
  logic             last_row;

  logic [31:0] old_r;
  logic [31:0] ui_r;
  logic [63:0] sqa;
  logic [31:0] c_r;
  logic [31:0] s_r;
  logic [31:0] rij;
  logic [31:0] uj;
  logic [31:0] m2;
  logic        sat_r;
  logic [1:0]  st_r;

  logic        res_valid;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  logic [63:0] diff;
  sat_word_t   mul_s;
  sat_word_t   sum_t;
  sat_word_t   sum_u;

  function automatic sat_word_t mul_sat(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sat_word_t          r;
    sh    = p >>> FRAC_BITS;
    r.sat = !((&sh[63:31]) || !(|sh[63:31]));
    r.val = r.sat ? (sh[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sh[31:0];
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_ORDER + c);
  endfunction

  always_comb begin
    if (32'(active_size) > 32'(MAX_ORDER)) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else if (active_size == '0) begin
      n_eff = CNT_W'(1);
    end else begin
      n_eff = CNT_W'(active_size);
    end
  end

  assign i_ix     = i_cnt[IDX_W-1:0];
  assign j_ix     = j_cnt[IDX_W-1:0];
  assign last_col = (i_cnt + CNT_W'(1)) == n_r;
  assign last_row = (j_cnt + CNT_W'(1)) == n_r;

  assign mul_s    = mul_sat(prod);
  assign sum_t    = add_sat(rij, mul_s.val);
  assign sum_u    = add_sat(m2, mul_s.val);
  assign diff     = sqa - prod;
  assign sqrt_rad = diff[63] ? 63'(-diff) : diff[62:0];

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (fac_we) begin
      fac_mem[fac_waddr] <= fac_wdata;
    end
    fac_q <= fac_mem[fac_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_q <= vec_mem[vec_raddr];
  end

  trod_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_q),
    .quot_sat (div_sat)
  );

  trod_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .rad      (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root),
    .root_sat (sqrt_sat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_valid) begin
          if (cmd.func == FUNC_READ_R && cmd.row_ok && cmd.col_ok) begin
            state_next = ST_READ;
          end else if (cmd.func == FUNC_RUN) begin
            state_next = ST_COL_RD;
          end
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_COL_RD: state_next = ST_COL_LD;
      ST_COL_LD: state_next = ST_SQ_A;
      ST_SQ_A:   state_next = ST_SQ_B;
      ST_SQ_B:   state_next = ST_SQ_C;
      ST_SQ_C:   state_next = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_DIAG;
        end
      end
      ST_DIAG: begin
        if (last_col || old_r == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (div_done) begin
          state_next = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (div_done) begin
          state_next = (c_r == '0) ? ST_DONE : ST_ROW_RD;
        end
      end
      ST_ROW_RD: state_next = ST_ROW_LD;
      ST_ROW_LD: state_next = ST_M1;
      ST_M1:     state_next = ST_M1W;
      ST_M1W:    state_next = ST_DIV_R;
      ST_DIV_R: begin
        if (div_done) begin
          state_next = ST_M2;
        end
      end
      ST_M2:     state_next = ST_M3;
      ST_M3:     state_next = last_row ? ST_COL_RD : ST_ROW_RD;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    fac_we     = 1'b0;
    fac_waddr  = addr_of(i_ix, j_ix);
    fac_raddr  = addr_of(i_ix, j_ix);
    fac_wdata  = div_q;
    vec_we     = 1'b0;
    vec_waddr  = j_ix;
    vec_raddr  = j_ix;
    vec_wdata  = sum_u.val;
    mul_a      = $signed(s_r);
    mul_b      = $signed(uj);
    div_start  = 1'b0;
    div_num    = {sum_t.val[31], sum_t.val};
    div_den    = c_r;
    sqrt_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_pop   = cmd_valid && !res_valid;
        fac_raddr = addr_of(IDX_W'(cmd.row), IDX_W'(cmd.col));
        fac_waddr = addr_of(IDX_W'(cmd.row), IDX_W'(cmd.col));
        fac_wdata = cmd.data;
        fac_we    = cmd_pop && cmd.func == FUNC_WRITE_R && cmd.row_ok && cmd.col_ok;
        vec_waddr = IDX_W'(cmd.row);
        vec_wdata = cmd.data;
        vec_we    = cmd_pop && cmd.func == FUNC_WRITE_V && cmd.row_ok;
      end
      ST_COL_RD: begin
        fac_raddr = addr_of(i_ix, i_ix);
        vec_raddr = i_ix;
      end
      ST_SQ_A: begin
        mul_a = $signed(old_r);
        mul_b = $signed(old_r);
      end
      ST_SQ_B: begin
        mul_a = $signed(ui_r);
        mul_b = $signed(ui_r);
      end
      ST_SQ_C: sqrt_start = 1'b1;
      ST_DIAG: begin
        fac_we    = 1'b1;
        fac_waddr = addr_of(i_ix, i_ix);
        fac_wdata = sqrt_root;
        div_start = !last_col && old_r != '0;
        div_num   = {1'b0, sqrt_root};
        div_den   = old_r;
      end
      ST_DIV_C: begin
        div_start = div_done;
        div_num   = 33'(-{ui_r[31], ui_r});
        div_den   = old_r;
      end
      ST_M1W: div_start = 1'b1;
      ST_DIV_R: begin
        fac_we = div_done;
        mul_a  = $signed(s_r);
        mul_b  = $signed(div_q);
      end
      ST_M2: begin
        mul_a = $signed(c_r);
        mul_b = $signed(uj);
      end
      ST_M3: vec_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_COL_LD: begin
        old_r <= fac_q;
        ui_r  <= vec_q;
      end
      ST_SQ_B: sqa <= prod;
      ST_DIV_C: begin
        if (div_done) begin
          c_r <= div_q;
        end
      end
      ST_DIV_S: begin
        if (div_done) begin
          s_r <= div_q;
        end
      end
      ST_ROW_LD: begin
        rij <= fac_q;
        uj  <= vec_q;
      end
      ST_M2: m2 <= mul_s.val;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      n_r       <= CNT_W'(1);
      sat_r     <= 1'b0;
      st_r      <= STATUS_OK;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            res_value  <= '0;
            res_status <= STATUS_OK;
            if (cmd.func == FUNC_RUN) begin
              i_cnt <= '0;
              n_r   <= n_eff;
              sat_r <= 1'b0;
            end else if (!(cmd.func == FUNC_READ_R && cmd.row_ok && cmd.col_ok)) begin
              res_valid <= 1'b1;
            end
          end
        end
        ST_READ: begin
          res_value <= fac_q;
          res_valid <= 1'b1;
        end
        ST_DIAG: begin
          sat_r <= sat_r | sqrt_sat;
          if (last_col) begin
            st_r <= (sat_r || sqrt_sat) ? STATUS_SAT : STATUS_OK;
          end else if (old_r == '0) begin
            st_r <= STATUS_PIVOT;
          end
        end
        ST_DIV_C: begin
          if (div_done) begin
            sat_r <= sat_r | div_sat;
          end
        end
        ST_DIV_S: begin
          if (div_done) begin
            sat_r <= sat_r | div_sat;
            j_cnt <= i_cnt + CNT_W'(1);
            if (c_r == '0) begin
              st_r <= STATUS_PIVOT;
            end
          end
        end
        ST_M1W: sat_r <= sat_r | mul_s.sat | sum_t.sat;
        ST_DIV_R: begin
          if (div_done) begin
            sat_r <= sat_r | div_sat;
          end
        end
        ST_M2: sat_r <= sat_r | mul_s.sat;
        ST_M3: begin
          sat_r <= sat_r | mul_s.sat | sum_u.sat;
          j_cnt <= j_cnt + CNT_W'(1);
          if (last_row) begin
            i_cnt <= i_cnt + CNT_W'(1);
          end
        end
        ST_DONE: begin
          res_status <= st_r;
          res_valid  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid  = res_valid;
  assign read_value = res_value;
  assign status     = res_status;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import trod_pkg::*;

  localparam int ORDER = MAX_ORDER_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  st;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        func_w = FUNC_WRITE_R;
  logic [3:0]        row_w = '0;
  logic [3:0]        col_w = '0;
  logic [31:0]       data_w = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       read_value;
  logic [1:0]        status;

  // Mirror of the block's stores and its order register.
  int          factor_img[ORDER*ORDER];
  int          vector_img[ORDER];
  int          order_reg = ACTIVE_SIZE_RESET;
  bit          sat_flag;
  answer_t     answer_q[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int runs_done = 0;
  int pivot_runs = 0;
  int sat_runs = 0;
  int reads_done = 0;

  always #5 clk = ~clk;

  triangular_rank_one_downdate_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func_w), .row_index(row_w),
    .col_index(col_w), .data_value(data_w), .out_valid(out_valid),
    .out_ready(out_ready), .read_value(read_value), .status(status)
  );

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clip32(p >>> FRAC);
  endfunction

  function automatic longint q_div(longint a, longint b);
    longint num;
    num = a <<< FRAC;
    return clip32(num / b);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int eff_order(int v);
    if (v < 1) return 1;
    if (v > ORDER) return ORDER;
    return v;
  endfunction

  // Hyperbolic rotation of u out of R, column by column.
  function automatic logic [1:0] downdate_factor();
    int n;
    longint old, ui, d, nd, c, s, rij, uj, t, rn;
    longint unsigned mag;
    n = eff_order(order_reg);
    sat_flag = 1'b0;
    for (int i = 0; i < n; i++) begin
      old = factor_img[i*ORDER+i];
      ui = vector_img[i];
      d = old * old - ui * ui;
      mag = (d < 0) ? -d : d;
      nd = clip32(longint'(int_sqrt(mag)));
      factor_img[i*ORDER+i] = int'(nd);
      if (i + 1 >= n) break;
      if (old == 0) return STATUS_PIVOT;
      c = q_div(nd, old);
      s = q_div(-ui, old);
      if (c == 0) return STATUS_PIVOT;
      for (int j = i + 1; j < n; j++) begin
        rij = factor_img[i*ORDER+j];
        uj = vector_img[j];
        t = clip32(rij + q_mul(s, uj));
        rn = q_div(t, c);
        factor_img[i*ORDER+j] = int'(rn);
        vector_img[j] = int'(clip32(q_mul(s, rn) + q_mul(c, uj)));
      end
    end
    return sat_flag ? STATUS_SAT : STATUS_OK;
  endfunction

  function automatic void predict_word(func_t f, int row, int col, int data);
    answer_t a;
    a.value = '0;
    a.st = STATUS_OK;
    case (f)
      FUNC_WRITE_R: factor_img[row*ORDER+col] = data;
      FUNC_READ_R: begin
        a.value = factor_img[row*ORDER+col];
        reads_done++;
      end
      FUNC_WRITE_V: vector_img[row] = data;
      default: begin
        a.st = downdate_factor();
        runs_done++;
        if (a.st == STATUS_PIVOT) pivot_runs++;
        if (a.st == STATUS_SAT) sat_runs++;
      end
    endcase
    answer_q.push_back(a);
  endfunction

  task automatic send_word(input func_t f, input int row, input int col, input int data);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func_w <= f;
    row_w <= row[3:0];
    col_w <= col[3:0];
    data_w <= data;
    do @(posedge clk); while (!in_ready);
    predict_word(f, row, col, data);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[SIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    order_reg = v;
  endtask

  function automatic int any_word();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int diag_value();
    int v;
    v = $urandom_range(2 << FRAC, 64 << FRAC);
    return $urandom_range(1) ? v : -v;
  endfunction

  // A loaded triangle, a loaded vector, one downdate, then a few reads.
  task automatic load_and_downdate();
    int n;
    n = eff_order(order_reg);
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++)
        send_word(FUNC_WRITE_R, i, j, (i == j) ? diag_value()
                  : int'($urandom_range(0, 16 << FRAC)) - (8 << FRAC));
    for (int i = 0; i < n; i++)
      send_word(FUNC_WRITE_V, i, 0, ($urandom_range(7) == 0) ? any_word()
                : int'($urandom_range(0, 2 << FRAC)) - (1 << FRAC));
    send_word(FUNC_RUN, $urandom_range(15), $urandom_range(15), $urandom);
    repeat (3) send_word(FUNC_READ_R, $urandom_range(n - 1), $urandom_range(n - 1), $urandom);
  endtask

  task automatic test_load_all();
    for (int r = 0; r < ORDER; r++)
      for (int c = 0; c < ORDER; c++)
        send_word(FUNC_WRITE_R, r, c, $urandom);
    for (int r = 0; r < ORDER; r++)
      send_word(FUNC_WRITE_V, r, $urandom_range(15), $urandom);
  endtask

  task automatic test_edges();
    set_order(1);
    send_word(FUNC_WRITE_R, 0, 0, 32'h8000_0000);
    send_word(FUNC_WRITE_V, 0, 0, 0);
    send_word(FUNC_RUN, 0, 0, 0);
    send_word(FUNC_READ_R, 0, 0, 0);
    // Zero diagonal in the last column needs no division.
    send_word(FUNC_WRITE_R, 0, 0, 0);
    send_word(FUNC_RUN, 0, 0, 0);
    set_order(2);
    send_word(FUNC_WRITE_R, 0, 0, 0);
    send_word(FUNC_RUN, 15, 15, -1);
    // Equal diagonal and vector give a zero cosine.
    send_word(FUNC_WRITE_R, 0, 0, 1);
    send_word(FUNC_WRITE_V, 0, 0, 1);
    send_word(FUNC_RUN, 0, 0, 0);
    send_word(FUNC_WRITE_R, 0, 0, 4 << FRAC);
    send_word(FUNC_WRITE_R, 0, 1, 1 << FRAC);
    send_word(FUNC_WRITE_R, 1, 1, 3 << FRAC);
    send_word(FUNC_WRITE_V, 0, 0, 1 << FRAC);
    send_word(FUNC_WRITE_V, 1, 0, 1 << (FRAC - 1));
    send_word(FUNC_RUN, 0, 0, 0);
    send_word(FUNC_READ_R, 0, 1, 0);
    send_word(FUNC_READ_R, 1, 0, 0);
    send_word(FUNC_WRITE_V, 0, 0, 32'h8000_0000);
    send_word(FUNC_RUN, 0, 0, 0);
    send_word(FUNC_WRITE_R, 15, 15, 32'h7FFF_FFFF);
    send_word(FUNC_READ_R, 15, 15, 0);
    set_order(0);
    send_word(FUNC_RUN, 0, 0, 0);
    set_order(31);
    send_word(FUNC_RUN, 0, 0, 0);
    send_word(FUNC_READ_R, 15, 15, 0);
  endtask

  task automatic test_traffic(input int idle_pct, input int stall, input int order,
                              input int count);
    int start;
    set_order(order);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(9) < 7) begin
        load_and_downdate();
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(func_t'($urandom_range(2)), $urandom_range(15), $urandom_range(15),
                    any_word());
      end
    end
  endtask

  task automatic test_backpressure();
    set_order(3);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= 400;
    repeat (16)
      send_word(func_t'($urandom_range(2)), $urandom_range(15), $urandom_range(15), $urandom);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected word: read_value %h status %0d", read_value, status);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (read_value !== a.value) begin
          $error("read_value: expected %h, got %h", a.value, read_value);
          errors++;
        end
        if (status !== a.st) begin
          $error("status: expected %0d, got %0d", a.st, status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_load_all();
    test_edges();
    test_traffic(0, 0, 3, 90);
    test_traffic(0, 0, 16, 90);
    test_traffic(58, 0, 5, 90);
    test_traffic(58, 0, 16, 90);
    test_traffic(0, 58, 2, 90);
    test_traffic(0, 58, 8, 90);
    test_traffic(36, 36, 4, 90);
    test_traffic(36, 36, 16, 90);
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
      errors++;
    end
    $display("Sent %0d words: %0d downdates (%0d zero pivot, %0d saturated), %0d reads,",
             words_sent, runs_done, pivot_runs, sat_runs, reads_done);
    $display("across orders 0 to 31 with sender gaps and receiver stalls.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
